[sv/ctc_pkg.sv]
// shared constants and types for the text console cell writer
package ctc_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int CELL_W      = 16;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0700;
    localparam logic [CELL_W-1:0] CODE_CR    = 16'd13;
    localparam logic [CELL_W-1:0] CODE_LF    = 16'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK      = 2'd2;

    typedef struct packed {
        logic              start;
        logic              copy;
        logic [CELL_W-1:0] fill;
    } sweep_cmd_t;

    typedef struct packed {
        logic busy;
        logic writing;
    } sweep_status_t;

endpackage

[sv/ctc_ram.sv]
// generic simple dual-port ram with registered read
module ctc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/ctc_sweep.sv]
// address sweep over the cell store for the reset clear and the scroll copy and fill
module ctc_sweep #(
    parameter int COLUMNS = ctc_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = ctc_pkg::DEFAULT_ROWS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ctc_pkg::sweep_cmd_t                  cmd,
    output ctc_pkg::sweep_status_t               status,
    input  logic [ctc_pkg::CELL_W-1:0]           rdata,
    output logic                                 we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      waddr,
    output logic [ctc_pkg::CELL_W-1:0]           wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      raddr
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic                       run_reg;
    logic                       copy_reg;
    logic [AW-1:0]              cnt_reg;
    logic [ctc_pkg::CELL_W-1:0] fill_reg;
    logic                       wv_reg;
    logic [AW-1:0]              waddr_reg;
    logic                       wsrc_reg;
    logic [AW:0]                src_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b1;
            copy_reg  <= 1'b0;
            cnt_reg   <= '0;
            fill_reg  <= ctc_pkg::CLEAR_CELL;
            wv_reg    <= 1'b0;
            waddr_reg <= '0;
            wsrc_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                run_reg  <= 1'b1;
                cnt_reg  <= '0;
                copy_reg <= cmd.copy;
                fill_reg <= cmd.fill;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + AW'(1);
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
            wv_reg    <= run_reg;
            waddr_reg <= cnt_reg;
            wsrc_reg  <= run_reg && copy_reg && (cnt_reg < AW'(CELLS - COLUMNS));
        end
    end

    // source cell sits one row below the destination
    assign src_addr = (AW + 1)'(cnt_reg) + (AW + 1)'(COLUMNS);
    assign raddr    = src_addr[AW-1:0];
    assign we       = wv_reg;
    assign waddr    = waddr_reg;
    assign wdata    = wsrc_reg ? rdata : fill_reg;

    assign status.busy    = run_reg | wv_reg;
    assign status.writing = wv_reg;

endmodule

[sv/text_console_cell_writer.sv]
// text console cell writer top level: cursor, command sequencer and output register
//
// channel  direction  payload
// s_*      in         tuser: kind; tdata: char_code[15:0] read_row[20:16] read_column[27:21]
// m_*      out        tdata: cell_value[15:0] cursor_row[20:16] cursor_column[27:21]
//                     scrolled[28]
// cfg_*    in         cfg_index selects foreground, background or blink; cfg_data value
//
// a put passes address multiply, ram write and output load; a read also waits on the
// ram read latency before the output load; s_tready returns the cycle after the load,
// and the load waits while the output register holds a result not yet taken
// a scroll adds a copy and fill sweep of the whole store on the one write port
// after reset the store is cleared with s_tready low
// a waiting result holds in the output register while the next item is taken
module text_console_cell_writer #(
    parameter int COLUMNS = ctc_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = ctc_pkg::DEFAULT_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ctc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // char_code, read_row, read_column, zero pad
    input  logic [ctc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cell_value, cursor_row, cursor_column, scrolled, zero pad
    output logic [ctc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int MW    = AW + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADDR   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDATA  = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic                       kind_reg;
    logic [ctc_pkg::CELL_W-1:0] code_reg;
    logic [ctc_pkg::ROW_FIELD_W-1:0] rrow_reg;
    logic [ctc_pkg::COL_FIELD_W-1:0] rcol_reg;
    logic                       in_range_reg;
    logic [AW-1:0]              addr_reg;
    logic [RW-1:0]              row_reg;
    logic [CW-1:0]              col_reg;
    logic [ctc_pkg::CELL_W-1:0] value_reg;
    logic                       scrolled_reg;
    logic [3:0]                 fg_reg;
    logic [3:0]                 bg_reg;
    logic                       blink_reg;
    logic                       m_tvalid_reg;
    logic [ctc_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    logic [7:0]                 attr;
    logic [ctc_pkg::CELL_W-1:0] attr_word;
    logic [MW-1:0]              row_sel;
    logic [MW-1:0]              col_sel;
    logic [MW-1:0]              prod;
    logic                       in_range;
    logic                       last_row;
    logic                       last_col;
    logic                       is_glyph;
    logic                       wrap;
    logic                       scroll_hit;
    logic                       top_we;
    logic                       out_load;
    logic [31:0]                row_wide;
    logic [31:0]                col_wide;

    ctc_pkg::sweep_cmd_t        sw_cmd;
    ctc_pkg::sweep_status_t     sw_status;
    logic                       sw_we;
    logic [AW-1:0]              sw_waddr;
    logic [ctc_pkg::CELL_W-1:0] sw_wdata;
    logic [AW-1:0]              sw_raddr;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ctc_pkg::CELL_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ctc_pkg::CELL_W-1:0] ram_rdata;

    assign attr      = {blink_reg | bg_reg[3], bg_reg[2:0], fg_reg};
    assign attr_word = {attr, 8'h00};

    always_comb
    begin
        if (kind_reg)
        begin
            row_sel = MW'(rrow_reg);
            col_sel = MW'(rcol_reg);
        end
        else
        begin
            row_sel = MW'(row_reg);
            col_sel = MW'(col_reg);
        end
    end

    assign prod     = row_sel * MW'(COLUMNS) + col_sel;
    assign in_range = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS);

    assign last_row   = row_reg == RW'(ROWS - 1);
    assign last_col   = col_reg == CW'(COLUMNS - 1);
    assign is_glyph   = (code_reg != ctc_pkg::CODE_CR) && (code_reg != ctc_pkg::CODE_LF);
    assign wrap       = (code_reg == ctc_pkg::CODE_LF) || (is_glyph && last_col);
    assign scroll_hit = wrap && last_row;

    assign top_we     = (state_reg == ST_EXEC) && !kind_reg && is_glyph;
    assign sw_cmd.start = (state_reg == ST_EXEC) && !kind_reg && scroll_hit;
    assign sw_cmd.copy  = 1'b1;
    assign sw_cmd.fill  = attr_word;

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) && !sw_status.busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (kind_reg)
                begin
                    state_next = ST_RDATA;
                end
                else if (scroll_hit)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDATA:
            begin
                state_next = ST_DONE;
            end
            ST_SCROLL:
            begin
                if (!sw_status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            fg_reg       <= 4'd7;
            bg_reg       <= 4'd0;
            blink_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    ctc_pkg::CFG_FOREGROUND: fg_reg    <= cfg_data[3:0];
                    ctc_pkg::CFG_BACKGROUND: bg_reg    <= cfg_data[3:0];
                    ctc_pkg::CFG_BLINK:      blink_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if ((state_reg == ST_EXEC) && !kind_reg)
            begin
                if (!is_glyph || last_col)
                begin
                    col_reg <= '0;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
                if (wrap && !last_row)
                begin
                    row_reg <= row_reg + RW'(1);
                end
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg     <= s_tuser[0];
            code_reg     <= s_tdata[15:0];
            rrow_reg     <= s_tdata[20:16];
            rcol_reg     <= s_tdata[27:21];
            value_reg    <= '0;
            scrolled_reg <= 1'b0;
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg     <= prod[AW-1:0];
            in_range_reg <= in_range;
        end
        if (sw_cmd.start)
        begin
            scrolled_reg <= 1'b1;
        end
        if ((state_reg == ST_RDATA) && in_range_reg)
        begin
            value_reg <= ram_rdata;
        end
        if (out_load)
        begin
            m_tdata_reg <= {3'b000, scrolled_reg,
                            col_wide[ctc_pkg::COL_FIELD_W-1:0],
                            row_wide[ctc_pkg::ROW_FIELD_W-1:0],
                            value_reg};
        end
    end

    assign row_wide = 32'(row_reg);
    assign col_wide = 32'(col_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // store port sharing: the sweep owns the ram while busy
    assign ram_we    = sw_we | top_we;
    assign ram_waddr = sw_status.busy ? sw_waddr : addr_reg;
    assign ram_wdata = sw_status.busy ? sw_wdata : (code_reg | attr_word);
    assign ram_raddr = sw_status.busy ? sw_raddr : addr_reg;

    ctc_sweep #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_sweep (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (sw_cmd),
        .status (sw_status),
        .rdata  (ram_rdata),
        .we     (sw_we),
        .waddr  (sw_waddr),
        .wdata  (sw_wdata),
        .raddr  (sw_raddr)
    );

    ctc_ram #(
        .WIDTH (ctc_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_ADDR))
        else $error("transfer did not start the sequencer");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(COLUMNS - 1))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= RW'(ROWS - 1))
        else $error("cursor row out of range");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(top_we && sw_status.busy))
        else $error("cell write during sweep");

    a_scroll_runs: assert property (@(posedge clk) disable iff (!rst_n)
        sw_cmd.start |=> (sw_status.busy && (state_reg == ST_SCROLL)))
        else $error("scroll sweep did not start");

endmodule
